@@ rtl/pcm_sample_to_s24_converter_defines.svh @@
// assertion helpers for the top-level converter rtl file
`ifndef PCM_SAMPLE_TO_S24_CONVERTER_DEFINES_SVH
`define PCM_SAMPLE_TO_S24_CONVERTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PCM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pcm converter check failed");

// next-cycle implication, checked out of reset
`define PCM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcm converter check failed");

`endif

@@ rtl/pcm_s24_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pcm_s24_pkg;

    typedef enum logic [2:0] {
        FMT_U8   = 3'd0,
        FMT_S8   = 3'd1,
        FMT_S16  = 3'd2,
        FMT_S24  = 3'd3,
        FMT_S32  = 3'd4,
        FMT_F32  = 3'd5,
        FMT_F64  = 3'd6,
        FMT_NONE = 3'd7
    } t_fmt;

    typedef enum logic [1:0] {
        KIND_INT   = 2'd0,
        KIND_FLOAT = 2'd1,
        KIND_ZERO  = 2'd2,
        KIND_CLAMP = 2'd3
    } t_kind;

    localparam logic [23:0] FULL_SCALE = 24'h7FFFFF;

    typedef struct packed {
        logic         valid;
        t_kind        kind;
        logic         is_f64;
        logic         sign;
        logic         wide;
        logic [23:0]  int_val;
        logic [75:0]  prod;
        logic [6:0]   shift;
    } t_s1;

    typedef struct packed {
        logic         valid;
        t_kind        kind;
        logic         sign;
        logic         wide;
        logic [23:0]  int_val;
        logic [53:0]  mag;
        logic [5:0]   rshift;
    } t_s2;

endpackage
`default_nettype wire

@@ rtl/pcm_s24_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pcm_s24_decode
    import pcm_s24_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_fmt        i_fmt,
    input  wire logic [63:0] i_raw,
    output t_s1              o_s1
);

    t_s1 r_s1;
    t_s1 n_s1;

    logic [7:0]  f_exp;
    logic [7:0]  u8_rec;
    logic [23:0] m32;
    logic [10:0] d_exp;
    logic [52:0] m64;
    logic [7:0]  s32;
    logic [11:0] s64;

    always_comb begin
        f_exp  = i_raw[30:23];
        d_exp  = i_raw[62:52];
        m32    = {1'b1, i_raw[22:0]};
        m64    = {1'b1, i_raw[51:0]};
        u8_rec = i_raw[7:0] ^ 8'h80;
        s32    = 8'd150 - f_exp;
        s64    = 12'd1075 - {1'b0, d_exp};

        n_s1         = '0;
        n_s1.valid   = i_valid;
        n_s1.kind    = KIND_INT;
        unique case (i_fmt)
            FMT_U8: begin
                n_s1.int_val = {{8{u8_rec[7]}}, u8_rec, 8'h00};
            end
            FMT_S8: begin
                n_s1.int_val = {{8{i_raw[7]}}, i_raw[7:0], 8'h00};
            end
            FMT_S16: begin
                n_s1.int_val = {{8{i_raw[15]}}, i_raw[15:0]};
            end
            FMT_S24: begin
                n_s1.int_val = i_raw[23:0];
                n_s1.wide    = 1'b1;
            end
            FMT_S32: begin
                n_s1.int_val = i_raw[31:8];
                n_s1.wide    = 1'b1;
            end
            FMT_F32: begin
                n_s1.wide   = 1'b1;
                n_s1.sign   = i_raw[31];
                n_s1.prod   = {29'b0, ({m32, 23'b0} - {23'b0, m32})};
                n_s1.shift  = s32[6:0];
                // nan gives zero, magnitude one or more clamps, below one lsb truncates to zero
                if (f_exp == 8'hFF && i_raw[22:0] != 23'b0) begin
                    n_s1.kind = KIND_ZERO;
                end else if (f_exp >= 8'd127) begin
                    n_s1.kind = KIND_CLAMP;
                end else if (f_exp < 8'd104) begin
                    n_s1.kind = KIND_ZERO;
                end else begin
                    n_s1.kind = KIND_FLOAT;
                end
            end
            FMT_F64: begin
                n_s1.wide   = 1'b1;
                n_s1.is_f64 = 1'b1;
                n_s1.sign   = i_raw[63];
                n_s1.prod   = {m64, 23'b0} - {23'b0, m64};
                n_s1.shift  = s64[6:0];
                if (d_exp == 11'h7FF && i_raw[51:0] != 52'b0) begin
                    n_s1.kind = KIND_ZERO;
                end else if (d_exp >= 11'd1023) begin
                    n_s1.kind = KIND_CLAMP;
                end else if (d_exp < 11'd1000) begin
                    n_s1.kind = KIND_ZERO;
                end else begin
                    n_s1.kind = KIND_FLOAT;
                end
            end
            FMT_NONE: begin
                n_s1.kind = KIND_ZERO;
            end
            default: begin
                n_s1.kind = KIND_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule
`default_nettype wire

@@ rtl/pcm_s24_round.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pcm_s24_round
    import pcm_s24_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_s1  i_s1,
    output t_s2       o_s2
);

    t_s2 r_s2;
    t_s2 n_s2;

    logic [52:0] keep;
    logic        guard;
    logic        sticky;
    logic        inc;
    logic [6:0]  k;
    logic [6:0]  rs;

    // round the exact product to the float's precision, nearest even
    always_comb begin
        if (i_s1.is_f64) begin
            if (i_s1.prod[75]) begin
                keep   = i_s1.prod[75:23];
                guard  = i_s1.prod[22];
                sticky = |i_s1.prod[21:0];
                k      = 7'd23;
            end else begin
                keep   = i_s1.prod[74:22];
                guard  = i_s1.prod[21];
                sticky = |i_s1.prod[20:0];
                k      = 7'd22;
            end
        end else begin
            if (i_s1.prod[46]) begin
                keep   = {29'b0, i_s1.prod[46:23]};
                guard  = i_s1.prod[22];
                sticky = |i_s1.prod[21:0];
                k      = 7'd23;
            end else begin
                keep   = {29'b0, i_s1.prod[45:22]};
                guard  = i_s1.prod[21];
                sticky = |i_s1.prod[20:0];
                k      = 7'd22;
            end
        end
        inc = guard & (sticky | keep[0]);
        rs  = i_s1.shift - k;

        n_s2.valid   = i_s1.valid;
        n_s2.kind    = i_s1.kind;
        n_s2.sign    = i_s1.sign;
        n_s2.wide    = i_s1.wide;
        n_s2.int_val = i_s1.int_val;
        n_s2.mag     = {1'b0, keep} + {53'b0, inc};
        n_s2.rshift  = rs[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule
`default_nettype wire

@@ rtl/pcm_s24_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pcm_s24_scale
    import pcm_s24_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_s2                i_s2,
    output logic                    o_strobe,
    output logic signed [23:0]      o_sample_value,
    output logic                    o_wide_sample
);

    logic               r_strobe;
    logic signed [23:0] r_value;
    logic               r_wide;
    logic signed [23:0] n_value;
    logic [53:0]        shifted;
    logic [23:0]        mag24;

    always_comb begin
        shifted = i_s2.mag >> i_s2.rshift;
        mag24   = shifted[23:0];
        unique case (i_s2.kind)
            KIND_INT:   n_value = i_s2.int_val;
            KIND_FLOAT: n_value = i_s2.sign ? -mag24 : mag24;
            KIND_CLAMP: n_value = i_s2.sign ? -FULL_SCALE : FULL_SCALE;
            KIND_ZERO:  n_value = '0;
            default:    n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_s2.valid;
        end
        r_value <= n_value;
        r_wide  <= i_s2.wide;
    end

    assign o_strobe       = r_strobe;
    assign o_sample_value = r_value;
    assign o_wide_sample  = r_wide;

endmodule
`default_nettype wire

@@ rtl/pcm_sample_to_s24_converter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// pcm sample converter: raw little-endian sample word in, signed 24-bit sample out
// input: a transaction is taken on each edge with start high and busy low;
//   busy is always low, so one sample can enter every cycle
// config: i_cfg_valid/o_cfg_ready write the 3-bit sample type; ready is always
//   high, and the type is sampled with each input, so write it while idle
// output: o_strobe marks o_sample_value and o_wide_sample for one cycle,
//   after the input passes the decode, round and scale registers; the receiver cannot stall
// pipeline: decode and exact product of the float mantissa by full scale,
//   round to the source precision, then shift, sign and select
// throughput is one sample per cycle, through the three register stages
// reset: sample type returns to s16, all stage valid bits clear, no strobe
module pcm_sample_to_s24_converter
    import pcm_s24_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [63:0]        i_sample_bytes,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_data,
    output logic                    o_strobe,
    output logic signed [23:0]      o_sample_value,
    output logic                    o_wide_sample
);

`include "pcm_sample_to_s24_converter_defines.svh"

    t_fmt        r_sample_type;
    t_s1         s1;
    t_s2         s2;
    logic [53:0] s2_scaled;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_type <= FMT_S16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sample_type <= t_fmt'(i_cfg_data);
        end
    end

    pcm_s24_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_fmt   (r_sample_type),
        .i_raw   (i_sample_bytes),
        .o_s1    (s1)
    );

    pcm_s24_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    pcm_s24_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s2           (s2),
        .o_strobe       (o_strobe),
        .o_sample_value (o_sample_value),
        .o_wide_sample  (o_wide_sample)
    );

    assign s2_scaled = s2.mag >> s2.rshift;

    // every transaction comes out through the decode, round and scale registers
    `PCM_ASSERT_IMP(a_latency, start && !busy, ##3 o_strobe)
    // no result without an earlier transaction at the pipeline input
    `PCM_ASSERT_IMP(a_no_spurious, o_strobe, $past(start, 3))
    // a config write lands in the type register
    `PCM_ASSERT_NXT(a_cfg_write, i_cfg_valid, r_sample_type == t_fmt'($past(i_cfg_data)))
    // a scaled float never goes beyond full scale
    `PCM_ASSERT_IMP(a_float_range, s2.valid && s2.kind == KIND_FLOAT, s2_scaled <= 54'h7FFFFF)

endmodule
`default_nettype wire
